>>> sv/cai_pkg.sv
// ----------------------------------------------------------------------------
// cai_pkg
// Shared widths, register indexes, pipeline word types and constant
// functions for the cylindrical arm inverse kinematics block.
// ----------------------------------------------------------------------------
package cai_pkg;

   // field widths
   localparam int IN_W       = 32;               // target and register width
   localparam int DW         = IN_W + 1;         // origin-relative difference
   localparam int GUARD_BITS = 6;
   localparam int CW         = 42;               // cordic x/y datapath
   localparam int UW         = CW - 1;           // non-negative x magnitude
   localparam int ZW         = 34;               // angle accumulator, q30
   localparam int ANGLE_FRAC = 30;
   localparam int ATAN_W     = 30;
   localparam int IKW        = 30;               // inverse gain, q30
   localparam int RW         = CW - GUARD_BITS;  // radius width
   localparam int EW         = RW + 2;           // extension before clamp
   localparam int YAW_W      = 19;
   localparam int TABLE_LEN  = 24;
   localparam int CSR_IDX_W  = 8;
   localparam int REQ_W      = 3 * IN_W;
   localparam int RSP_W      = 88;

   localparam int CORDIC_STAGES_DEFAULT = 16;
   localparam int FRACTION_BITS_DEFAULT = 16;

   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = PI_Q30 / 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BASE_X   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_Y   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_Z   = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ARM_LEN  = 8'd3;
   localparam logic [CSR_IDX_W-1:0] REG_EXT_MIN  = 8'd4;
   localparam logic [CSR_IDX_W-1:0] REG_EXT_MAX  = 8'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LIFT_MIN = 8'd6;
   localparam logic [CSR_IDX_W-1:0] REG_LIFT_MAX = 8'd7;

   typedef struct packed {
      logic signed [IN_W-1:0] base_x;
      logic signed [IN_W-1:0] base_y;
      logic signed [IN_W-1:0] base_z;
      logic signed [IN_W-1:0] arm_base_length;
      logic signed [IN_W-1:0] extension_min;
      logic signed [IN_W-1:0] extension_max;
      logic signed [IN_W-1:0] lift_min;
      logic signed [IN_W-1:0] lift_max;
   } cfg_type;

   // word carried through the rotation stages
   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic signed [DW-1:0] dz;
      logic                 zero;
   } work_type;

   // atan(2^-i) truncated to q30
   function automatic logic [ATAN_W-1:0] atan_q30(input int i);
      logic [ATAN_W-1:0] a;
      case (i)
         0:       a = 30'd843314856;
         1:       a = 30'd497837829;
         2:       a = 30'd263043836;
         3:       a = 30'd133525158;
         4:       a = 30'd67021686;
         5:       a = 30'd33543515;
         6:       a = 30'd16775850;
         7:       a = 30'd8388437;
         8:       a = 30'd4194282;
         9:       a = 30'd2097149;
         10:      a = 30'd1048575;
         11:      a = 30'd524287;
         12:      a = 30'd262143;
         13:      a = 30'd131071;
         14:      a = 30'd65535;
         15:      a = 30'd32767;
         16:      a = 30'd16383;
         17:      a = 30'd8191;
         18:      a = 30'd4095;
         19:      a = 30'd2047;
         20:      a = 30'd1023;
         21:      a = 30'd511;
         22:      a = 30'd255;
         23:      a = 30'd127;
         default: a = '0;
      endcase
      return a;
   endfunction

   // 1/K in q30 for n rotation stages, evaluated at elaboration
   function automatic logic [63:0] inv_gain_q30(input int n);
      logic [63:0] k2;
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bit_v;
      logic [63:0] num;
      logic [63:0] q;
      logic [64:0] rem;
      k2 = 64'd1 << ANGLE_FRAC;
      for (int i = 0; i < n; i++) begin
         k2 = k2 + (k2 >> (2 * i));
      end
      // integer square root of k2 * 2^30
      v     = k2 << ANGLE_FRAC;
      res   = '0;
      bit_v = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
         if (v >= res + bit_v) begin
            v   = v - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      // rounded 2^60 / k by shift and subtract
      num = (64'd1 << 60) + (res >> 1);
      rem = '0;
      q   = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, res}) begin
            rem  = rem - {1'b0, res};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

endpackage

>>> sv/cai_front.sv
// ----------------------------------------------------------------------------
// cai_front
// Two pipeline stages: origin subtraction, then guard shift and the
// quarter turn that brings left half plane vectors into the right half.
// ----------------------------------------------------------------------------
module cai_front (
   input  logic                             clock,
   input  logic                             reset,
   input  cai_pkg::cfg_type                 cfg,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic signed [cai_pkg::IN_W-1:0]  target_x,
   input  logic signed [cai_pkg::IN_W-1:0]  target_y,
   input  logic signed [cai_pkg::IN_W-1:0]  target_z,
   output logic                             out_valid,
   input  logic                             out_ready,
   output cai_pkg::work_type                out_work
);

   localparam int DW   = cai_pkg::DW;
   localparam int CW   = cai_pkg::CW;
   localparam int ZW   = cai_pkg::ZW;
   localparam int G    = cai_pkg::GUARD_BITS;
   localparam int EXTB = CW - DW - G;
   localparam logic signed [ZW-1:0] HALF_PI = ZW'(cai_pkg::HALF_PI_Q30);

   logic                 sub_valid_ff;
   logic                 sub_ready;
   logic signed [DW-1:0] dx_ff, dx_in;
   logic signed [DW-1:0] dy_ff, dy_in;
   logic signed [DW-1:0] dz_ff, dz_in;

   logic                 rot_valid_ff;
   cai_pkg::work_type    rot_work_ff, rot_work_in;

   logic signed [CW-1:0] xg;
   logic signed [CW-1:0] yg;

   assign sub_ready = !sub_valid_ff || !rot_valid_ff || out_ready;
   assign in_ready  = !sub_valid_ff || sub_ready && 1'b1;

   always_comb begin
      dx_in = DW'(target_x) - DW'(cfg.base_x);
      dy_in = DW'(target_y) - DW'(cfg.base_y);
      dz_in = DW'(target_z) - DW'(cfg.base_z);
   end

   always_comb begin
      xg = {{EXTB{dx_ff[DW-1]}}, dx_ff, {G{1'b0}}};
      yg = {{EXTB{dy_ff[DW-1]}}, dy_ff, {G{1'b0}}};
      rot_work_in.dz   = dz_ff;
      rot_work_in.zero = (dx_ff == '0) && (dy_ff == '0);
      if (xg < 0) begin
         if (yg >= 0) begin
            rot_work_in.x = yg;
            rot_work_in.y = -xg;
            rot_work_in.z = HALF_PI;
         end else begin
            rot_work_in.x = -yg;
            rot_work_in.y = xg;
            rot_work_in.z = -HALF_PI;
         end
      end else begin
         rot_work_in.x = xg;
         rot_work_in.y = yg;
         rot_work_in.z = '0;
      end
   end

   // stage one: subtraction
   always_ff @(posedge clock) begin
      if (reset) begin
         sub_valid_ff <= 1'b0;
      end else if (in_ready) begin
         sub_valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         dz_ff <= dz_in;
      end
   end

   // stage two: pre-rotation
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_valid_ff <= 1'b0;
      end else if (!rot_valid_ff || out_ready) begin
         rot_valid_ff <= sub_valid_ff;
      end
      if (sub_valid_ff && (!rot_valid_ff || out_ready)) begin
         rot_work_ff <= rot_work_in;
      end
   end

   assign out_valid = rot_valid_ff;
   assign out_work  = rot_work_ff;

endmodule

>>> sv/cai_cordic_stage.sv
// ----------------------------------------------------------------------------
// cai_cordic_stage
// One registered vectoring iteration: shift-add on x and y, table angle
// into the accumulator, direction taken from the sign of y.
// ----------------------------------------------------------------------------
module cai_cordic_stage #(
   parameter int STAGE = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cai_pkg::work_type in_work,
   output logic              out_valid,
   input  logic              out_ready,
   output cai_pkg::work_type out_work
);

   localparam int CW = cai_pkg::CW;
   localparam int ZW = cai_pkg::ZW;
   localparam logic signed [ZW-1:0] ATAN = ZW'(cai_pkg::atan_q30(STAGE));

   logic                 valid_ff;
   cai_pkg::work_type    work_ff, work_in;
   logic signed [CW-1:0] xs;
   logic signed [CW-1:0] ys;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      xs = in_work.x >>> STAGE;
      ys = in_work.y >>> STAGE;
      work_in = in_work;
      if (in_work.y >= 0) begin
         work_in.x = in_work.x + ys;
         work_in.y = in_work.y - xs;
         work_in.z = in_work.z + ATAN;
      end else begin
         work_in.x = in_work.x - ys;
         work_in.y = in_work.y + xs;
         work_in.z = in_work.z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

>>> sv/cai_back.sv
// ----------------------------------------------------------------------------
// cai_back
// Four pipeline stages: gain multiply in two partial products and yaw
// rounding, product sum and yaw wrap, extension subtract and lift clamp,
// extension clamp into the output register.
// ----------------------------------------------------------------------------
module cai_back #(
   parameter int CORDIC_STAGES = cai_pkg::CORDIC_STAGES_DEFAULT,
   parameter int FRACTION_BITS = cai_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cai_pkg::cfg_type                  cfg,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  cai_pkg::work_type                 in_work,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [cai_pkg::IN_W-1:0]   out_extension,
   output logic signed [cai_pkg::YAW_W-1:0]  out_yaw,
   output logic signed [cai_pkg::IN_W-1:0]   out_lift,
   output logic                              out_in_range
);

   localparam int IN_W  = cai_pkg::IN_W;
   localparam int DW    = cai_pkg::DW;
   localparam int CW    = cai_pkg::CW;
   localparam int UW    = cai_pkg::UW;
   localparam int ZW    = cai_pkg::ZW;
   localparam int IKW   = cai_pkg::IKW;
   localparam int RW    = cai_pkg::RW;
   localparam int EW    = cai_pkg::EW;
   localparam int YAW_W = cai_pkg::YAW_W;
   localparam int G     = cai_pkg::GUARD_BITS;
   localparam int AF    = cai_pkg::ANGLE_FRAC;
   localparam int LO_W  = 32 + IKW;
   localparam int HI_W  = (UW - 32) + IKW;
   localparam int QW    = CW;
   localparam int FS    = AF - FRACTION_BITS;

   localparam logic [63:0]    INVK64 = cai_pkg::inv_gain_q30(CORDIC_STAGES);
   localparam logic [IKW-1:0] INVK   = INVK64[IKW-1:0];
   localparam longint         PI_L   = (cai_pkg::PI_Q30 + (longint'(1) << (FS - 1))) >>> FS;
   localparam logic signed [ZW-1:0] PI_Q      = ZW'(PI_L);
   localparam logic signed [ZW-1:0] TWO_PI_Q  = ZW'(2 * PI_L);
   localparam logic signed [ZW-1:0] YAW_ROUND = ZW'(longint'(1) << (FS - 1));

   // lower bound first, upper bound wins; msb of result is the clamp hit
   function automatic logic [EW:0] clamp(input logic signed [EW-1:0] v,
                                         input logic signed [EW-1:0] lo,
                                         input logic signed [EW-1:0] hi);
      logic signed [EW-1:0] c;
      logic                 hit;
      hit = 1'b0;
      c   = v;
      if (c < lo) begin
         c   = lo;
         hit = 1'b1;
      end
      if (c > hi) begin
         c   = hi;
         hit = 1'b1;
      end
      return {hit, c};
   endfunction

   function automatic logic signed [EW-1:0] sx(input logic signed [IN_W-1:0] v);
      return EW'(v);
   endfunction

   // stage 1
   logic                 v1_ff;
   logic [LO_W-1:0]      lo_ff, lo_in;
   logic [HI_W-1:0]      hi_ff, hi_in;
   logic signed [ZW-1:0] yaw1_ff, yaw1_in;
   logic signed [DW-1:0] dz1_ff;
   logic                 zero1_ff;
   logic [UW-1:0]        ux;
   logic signed [ZW-1:0] z_eff;
   logic signed [ZW-1:0] yaw_sum;

   // stage 2
   logic                    v2_ff;
   logic [RW-1:0]           radius2_ff, radius2_in;
   logic signed [YAW_W-1:0] yaw2_ff, yaw2_in;
   logic signed [DW-1:0]    dz2_ff;
   logic [QW-1:0]           q_sum;
   logic signed [ZW-1:0]    yaw_w1;
   logic signed [ZW-1:0]    yaw_w2;

   // stage 3
   logic                    v3_ff;
   logic signed [EW-1:0]    ext3_ff, ext3_in;
   logic signed [IN_W-1:0]  lift3_ff, lift3_in;
   logic                    ok3_ff, ok3_in;
   logic signed [YAW_W-1:0] yaw3_ff;
   logic [EW:0]             lift_c;

   // stage 4
   logic                    v4_ff;
   logic signed [IN_W-1:0]  ext4_ff, ext4_in;
   logic signed [YAW_W-1:0] yaw4_ff;
   logic signed [IN_W-1:0]  lift4_ff;
   logic                    ok4_ff, ok4_in;
   logic [EW:0]             ext_c;

   logic r1, r2, r3, r4;

   assign r4       = !v4_ff || out_ready;
   assign r3       = !v3_ff || r4;
   assign r2       = !v2_ff || r3;
   assign r1       = !v1_ff || r2;
   assign in_ready = r1;

   always_comb begin
      ux      = in_work.x < 0 ? '0 : UW'(in_work.x);
      lo_in   = LO_W'(ux[31:0]) * LO_W'(INVK);
      hi_in   = HI_W'(ux[UW-1:32]) * HI_W'(INVK);
      z_eff   = in_work.zero ? '0 : in_work.z;
      yaw_sum = z_eff + YAW_ROUND;
      yaw1_in = yaw_sum >>> FS;
   end

   always_comb begin
      q_sum      = {1'b0, hi_ff, 2'b00} + QW'(lo_ff[LO_W-1:AF]);
      radius2_in = zero1_ff ? '0 : q_sum[QW-1:G];
      // pi maps to -pi
      yaw_w1     = (yaw1_ff >= PI_Q) ? yaw1_ff - TWO_PI_Q : yaw1_ff;
      yaw_w2     = (yaw_w1 < -PI_Q) ? yaw_w1 + TWO_PI_Q : yaw_w1;
      yaw2_in    = yaw_w2[YAW_W-1:0];
   end

   always_comb begin
      ext3_in  = EW'({2'b00, radius2_ff}) - sx(cfg.arm_base_length);
      lift_c   = clamp(EW'(dz2_ff), sx(cfg.lift_min), sx(cfg.lift_max));
      lift3_in = lift_c[IN_W-1:0];
      ok3_in   = !lift_c[EW];
   end

   always_comb begin
      ext_c   = clamp(ext3_ff, sx(cfg.extension_min), sx(cfg.extension_max));
      ext4_in = ext_c[IN_W-1:0];
      ok4_in  = ok3_ff && !ext_c[EW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= in_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
         if (r4) v4_ff <= v3_ff;
      end
      if (in_valid && r1) begin
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         yaw1_ff  <= yaw1_in;
         dz1_ff   <= in_work.dz;
         zero1_ff <= in_work.zero;
      end
      if (v1_ff && r2) begin
         radius2_ff <= radius2_in;
         yaw2_ff    <= yaw2_in;
         dz2_ff     <= dz1_ff;
      end
      if (v2_ff && r3) begin
         ext3_ff  <= ext3_in;
         lift3_ff <= lift3_in;
         ok3_ff   <= ok3_in;
         yaw3_ff  <= yaw2_ff;
      end
      if (v3_ff && r4) begin
         ext4_ff  <= ext4_in;
         ok4_ff   <= ok4_in;
         yaw4_ff  <= yaw3_ff;
         lift4_ff <= lift3_ff;
      end
   end

   assign out_valid     = v4_ff;
   assign out_extension = ext4_ff;
   assign out_yaw       = yaw4_ff;
   assign out_lift      = lift4_ff;
   assign out_in_range  = ok4_ff;

endmodule

>>> sv/cylindrical_arm_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// cylindrical_arm_inverse_kinematics
// Target point to lift, yaw and extension for a cylindrical arm, through a
// fully pipelined cordic vectoring chain.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  req_tdata  x, y, z
//   rsp      out        rsp_tvalid/rsp_tready  rsp_tdata  ext, yaw, lift, ok
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// one word per cycle unless stalled by rsp_tready; the pipeline has two front
// stages, one per rotation stage, and four for gain multiply, wrap and clamps.
// every stage holds its own valid bit, so bubbles close up under a stall and
// a held output word does not block the stages behind it from filling.
// reset clears the valid bits and the config registers to zero; csr_ready is always
// high and register writes take effect on the next cycle.
// ----------------------------------------------------------------------------
module cylindrical_arm_inverse_kinematics #(
   parameter int CORDIC_STAGES = cai_pkg::CORDIC_STAGES_DEFAULT,
   parameter int FRACTION_BITS = cai_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cai_pkg::REQ_W-1:0]         req_tdata,   // target_x, target_y, target_z
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cai_pkg::RSP_W-1:0]         rsp_tdata,   // extension, yaw, lift, in_range
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cai_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cai_pkg::IN_W-1:0]          csr_data
);

   localparam int IN_W  = cai_pkg::IN_W;
   localparam int YAW_W = cai_pkg::YAW_W;
   localparam int PAD_W = cai_pkg::RSP_W - (2 * IN_W + YAW_W + 1);

   cai_pkg::cfg_type cfg_ff;

   logic                    stage_valid [0:CORDIC_STAGES];
   logic                    stage_ready [0:CORDIC_STAGES];
   cai_pkg::work_type       stage_work  [0:CORDIC_STAGES];

   logic signed [IN_W-1:0]  extension;
   logic signed [YAW_W-1:0] yaw;
   logic signed [IN_W-1:0]  lift;
   logic                    in_range;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cai_pkg::REG_BASE_X:   cfg_ff.base_x          <= csr_data;
            cai_pkg::REG_BASE_Y:   cfg_ff.base_y          <= csr_data;
            cai_pkg::REG_BASE_Z:   cfg_ff.base_z          <= csr_data;
            cai_pkg::REG_ARM_LEN:  cfg_ff.arm_base_length <= csr_data;
            cai_pkg::REG_EXT_MIN:  cfg_ff.extension_min   <= csr_data;
            cai_pkg::REG_EXT_MAX:  cfg_ff.extension_max   <= csr_data;
            cai_pkg::REG_LIFT_MIN: cfg_ff.lift_min        <= csr_data;
            cai_pkg::REG_LIFT_MAX: cfg_ff.lift_max        <= csr_data;
            default: ;
         endcase
      end
   end

   cai_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .target_x  (req_tdata[IN_W-1:0]),
      .target_y  (req_tdata[2*IN_W-1:IN_W]),
      .target_z  (req_tdata[3*IN_W-1:2*IN_W]),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_work  (stage_work[0])
   );

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      cai_cordic_stage #(
         .STAGE (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_work   (stage_work[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_work  (stage_work[i+1])
      );
   end

   cai_back #(
      .CORDIC_STAGES (CORDIC_STAGES),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (stage_valid[CORDIC_STAGES]),
      .in_ready      (stage_ready[CORDIC_STAGES]),
      .in_work       (stage_work[CORDIC_STAGES]),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_extension (extension),
      .out_yaw       (yaw),
      .out_lift      (lift),
      .out_in_range  (in_range)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, in_range, lift, yaw, extension};

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cylindrical arm inverse kinematics pipeline.
// Target points stream in and solved poses stream out, with random gaps and
// backpressure. An in-bench fixed-point model predicts every pose, and each
// output word is checked field by field. Register sets run from reset values
// through directed geometry to random and extreme settings.
// ----------------------------------------------------------------------------
module tb;

   localparam int          NUM_REGS      = 8;
   localparam int          ROT_STAGES    = 16;
   localparam int          ANGLE_SHIFT   = 30 - 16;
   localparam int          PIPE_LATENCY  = ROT_STAGES + 6;
   localparam longint      PI_RAD_Q30    = 64'sd3373259426;
   localparam logic [31:0] Q_MAX         = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN         = 32'h8000_0000;
   localparam logic [cai_pkg::CSR_IDX_W-1:0] REG_UNUSED_LO = 8'd8;
   localparam logic [cai_pkg::CSR_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

   typedef struct packed {
      logic signed [31:0] extension;
      logic signed [18:0] yaw;
      logic signed [31:0] lift;
      logic               in_range;
   } arm_pose_type;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [cai_pkg::REQ_W-1:0]     req_tdata  = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [cai_pkg::RSP_W-1:0]     rsp_tdata;
   logic                          csr_valid  = 1'b0;
   logic                          csr_ready;
   logic [cai_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [cai_pkg::IN_W-1:0]      csr_data   = '0;

   longint            arm_cfg [NUM_REGS];
   longint            rot_angle [ROT_STAGES] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287,
      262143, 131071, 65535, 32767};
   longint unsigned   inv_gain;
   arm_pose_type      expected_poses [$];
   int unsigned       mismatch_count = 0;
   bit                idle_enable    = 1'b1;
   int unsigned       ready_hold     = 0;

   always #5 clock = ~clock;

   cylindrical_arm_inverse_kinematics dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // target_x, target_y, target_z
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // extension, yaw, lift, in_range, zero pad
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 1/K in q30 for the rotation chain
   function automatic longint unsigned cordic_inv_gain();
      longint unsigned k2, v, root, b;
      int i;
      k2 = 64'd1 << 30;
      for (i = 0; i < ROT_STAGES; i++) k2 += k2 >> (2 * i);
      v    = k2 << 30;
      root = 0;
      b    = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= root + b) begin
            v    = v - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b >>= 2;
      end
      return ((64'd1 << 60) + root / 2) / root;
   endfunction

   function automatic arm_pose_type solve_pose(input logic [31:0] tx, ty, tz);
      longint          dx, dy, dz, px, py, ang, xs, ys, t, radius, heading, pi_q;
      longint          ext, lift;
      longint unsigned ux, lo_p, hi_p, q;
      bit              fits;
      int              i;
      arm_pose_type    p;
      dx     = longint'($signed(tx)) - arm_cfg[cai_pkg::REG_BASE_X];
      dy     = longint'($signed(ty)) - arm_cfg[cai_pkg::REG_BASE_Y];
      dz     = longint'($signed(tz)) - arm_cfg[cai_pkg::REG_BASE_Z];
      radius = 0;
      ang    = 0;
      fits   = 1'b1;
      if (dx != 0 || dy != 0) begin
         px = dx <<< cai_pkg::GUARD_BITS;
         py = dy <<< cai_pkg::GUARD_BITS;
         // left half plane: pre-rotate by a quarter turn
         if (px < 0) begin
            if (py >= 0) begin
               t = px; px = py; py = -t; ang = PI_RAD_Q30 / 2;
            end else begin
               t = px; px = -py; py = t; ang = -(PI_RAD_Q30 / 2);
            end
         end
         for (i = 0; i < ROT_STAGES; i++) begin
            xs = px >>> i;
            ys = py >>> i;
            if (py >= 0) begin
               px += ys; py -= xs; ang += rot_angle[i];
            end else begin
               px -= ys; py += xs; ang -= rot_angle[i];
            end
         end
         ux     = (px < 0) ? 64'd0 : px;
         lo_p   = (ux & 64'hFFFF_FFFF) * inv_gain;
         hi_p   = (ux >> 32) * inv_gain;
         q      = (hi_p << 2) + (lo_p >> 30);
         radius = longint'(q >> cai_pkg::GUARD_BITS);
      end
      heading = (ang + (64'sd1 <<< (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
      pi_q    = (PI_RAD_Q30 + (64'sd1 <<< (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
      if (heading >= pi_q) heading -= 2 * pi_q;
      if (heading < -pi_q) heading += 2 * pi_q;
      // lower bound first, upper bound wins
      ext = radius - arm_cfg[cai_pkg::REG_ARM_LEN];
      if (ext < arm_cfg[cai_pkg::REG_EXT_MIN]) begin
         ext = arm_cfg[cai_pkg::REG_EXT_MIN]; fits = 1'b0;
      end
      if (ext > arm_cfg[cai_pkg::REG_EXT_MAX]) begin
         ext = arm_cfg[cai_pkg::REG_EXT_MAX]; fits = 1'b0;
      end
      lift = dz;
      if (lift < arm_cfg[cai_pkg::REG_LIFT_MIN]) begin
         lift = arm_cfg[cai_pkg::REG_LIFT_MIN]; fits = 1'b0;
      end
      if (lift > arm_cfg[cai_pkg::REG_LIFT_MAX]) begin
         lift = arm_cfg[cai_pkg::REG_LIFT_MAX]; fits = 1'b0;
      end
      p.extension = ext[31:0];
      p.yaw       = heading[18:0];
      p.lift      = lift[31:0];
      p.in_range  = fits;
      return p;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // register shadow, prediction on accept, and output check
   always @(posedge clock) begin
      arm_pose_type want;
      arm_pose_type got;
      if (!reset) begin
         if (csr_valid && csr_ready && csr_index < NUM_REGS)
            arm_cfg[csr_index] = longint'($signed(csr_data));
         if (req_tvalid && req_tready)
            expected_poses.push_back(solve_pose(req_tdata[31:0], req_tdata[63:32],
                                                req_tdata[95:64]));
         if (rsp_tvalid && rsp_tready) begin
            got.extension = rsp_tdata[31:0];
            got.yaw       = rsp_tdata[50:32];
            got.lift      = rsp_tdata[82:51];
            got.in_range  = rsp_tdata[83];
            if (expected_poses.size() == 0) begin
               report_mismatch("unexpected word", 0, 0);
            end else begin
               want = expected_poses.pop_front();
               if (got.extension != want.extension)
                  report_mismatch("extension", got.extension, want.extension);
               if (got.yaw != want.yaw)
                  report_mismatch("yaw", got.yaw, want.yaw);
               if (got.lift != want.lift)
                  report_mismatch("lift", got.lift, want.lift);
               if (got.in_range != want.in_range)
                  report_mismatch("in_range", got.in_range, want.in_range);
            end
         end
      end
   end

   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!idle_enable || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // output backpressure
   always @(posedge clock) begin
      if (!idle_enable) begin
         rsp_tready <= 1'b1;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
         ready_hold <= idle_len();
      end
   end

   function automatic logic [31:0] metres(input int m);
      return m <<< 16;
   endfunction

   function automatic logic [cai_pkg::CSR_IDX_W-1:0] reg_at(input int i);
      case (i)
         0:       return cai_pkg::REG_BASE_X;
         1:       return cai_pkg::REG_BASE_Y;
         2:       return cai_pkg::REG_BASE_Z;
         3:       return cai_pkg::REG_ARM_LEN;
         4:       return cai_pkg::REG_EXT_MIN;
         5:       return cai_pkg::REG_EXT_MAX;
         6:       return cai_pkg::REG_LIFT_MIN;
         default: return cai_pkg::REG_LIFT_MAX;
      endcase
   endfunction

   // leaves tvalid high after accept; drain lowers it, and so does the next call if it idles first
   task automatic send_target(input logic [31:0] tx, ty, tz);
      int unsigned gap;
      gap = idle_len();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {tz, ty, tx};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (expected_poses.size() != 0);
      @(posedge clock);
   endtask

   // block is idle on entry; writes every register in index order
   task automatic program_arm(input logic [31:0] v [NUM_REGS], input bit poke_unused);
      int i;
      if (poke_unused) begin
         csr_valid <= 1'b1;
         csr_index <= REG_UNUSED_LO;
         csr_data  <= $urandom;
         do @(posedge clock); while (!csr_ready);
         csr_index <= REG_UNUSED_HI;
         csr_data  <= $urandom;
         do @(posedge clock); while (!csr_ready);
      end
      for (i = 0; i < NUM_REGS; i++) begin
         csr_valid <= 1'b1;
         csr_index <= reg_at(i);
         csr_data  <= v[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_values();
      // all limits zero: everything clamps to zero, heading still solved
      send_target(metres(0), metres(0), metres(0));
      send_target(metres(-5), metres(3), metres(7));
      send_target(Q_MAX, Q_MIN, Q_MAX);
      drain();
   endtask

   task automatic test_headings();
      program_arm('{32'd0, 32'd0, 32'd0, 32'd0, Q_MIN, Q_MAX, Q_MIN, Q_MAX}, 1'b1);
      send_target(metres(0), metres(0), metres(0));         // zero vector
      send_target(metres(1), metres(0), 32'h0000_8000);
      send_target(metres(0), metres(1), metres(0));
      send_target(metres(-1), metres(0), metres(0));        // heading of pi wraps to -pi
      send_target(metres(0), metres(-1), metres(0));
      send_target(metres(1), metres(1), metres(-2));
      send_target(metres(-1), metres(1), metres(3));        // left half, dy >= 0
      send_target(metres(-1), metres(-1), metres(0));       // left half, dy < 0
      send_target(metres(2), metres(-3), metres(1));
      drain();
   endtask

   task automatic test_span_extremes();
      program_arm('{Q_MAX, Q_MIN, Q_MAX, 32'd0, Q_MIN, Q_MAX, Q_MIN, Q_MAX}, 1'b0);
      send_target(Q_MIN, Q_MAX, Q_MIN);
      send_target(Q_MAX, Q_MIN, Q_MAX);                     // target on the origin
      send_target(32'd0, 32'd0, 32'd0);
      drain();
      program_arm('{Q_MIN, Q_MIN, Q_MIN, 32'd0, Q_MIN, Q_MAX, Q_MIN, Q_MAX}, 1'b1);
      send_target(Q_MAX, Q_MAX, Q_MAX);
      drain();
   endtask

   task automatic test_clamps();
      program_arm('{32'd0, 32'd0, 32'd0, Q_MAX, metres(-1000), metres(5000),
                    metres(10), metres(20)}, 1'b0);
      send_target(metres(3), metres(4), metres(15));
      send_target(Q_MAX, Q_MAX, metres(5));
      send_target(metres(-7), metres(2), metres(25));
      drain();
      // inverted windows: the upper bound wins
      program_arm('{32'd0, 32'd0, 32'd0, Q_MIN, metres(100), metres(-100),
                    metres(50), metres(-50)}, 1'b0);
      send_target(metres(1), metres(1), metres(0));
      send_target(metres(-200), metres(0), metres(60));
      send_target(metres(0), metres(0), metres(-60));
      drain();
   endtask

   function automatic logic [31:0] rand_coord(input logic [31:0] centre);
      int unsigned r;
      logic [19:0] offs;
      r    = $urandom_range(0, 9);
      offs = $urandom;
      if (r == 0) begin
         case ($urandom_range(0, 3))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2:       return 32'd0;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      if (r < 6) return centre + {{12{offs[19]}}, offs};
      return $urandom;
   endfunction

   task automatic test_random_sweep();
      logic [31:0] v [NUM_REGS];
      int phase, n, i;
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: v = '{32'd0, 32'd0, 32'd0, 32'd0, Q_MIN, Q_MAX, Q_MIN, Q_MAX};
            1: v = '{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX};
            2: v = '{Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN};
            4: for (i = 0; i < NUM_REGS; i++) v[i] = $urandom;
            default: begin
               // windows that the near-origin targets straddle
               v[0] = $urandom;
               v[1] = $urandom;
               v[2] = $urandom;
               v[3] = $urandom_range(0, 1 << 20);
               v[4] = -$urandom_range(0, 1 << 20);
               v[5] = $urandom_range(0, 1 << 20);
               v[6] = -$urandom_range(0, 1 << 19);
               v[7] = $urandom_range(0, 1 << 19);
            end
         endcase
         program_arm(v, phase == 0);
         idle_enable = (phase != 3);
         for (n = 0; n < 125; n++)
            send_target(rand_coord(v[0]), rand_coord(v[1]), rand_coord(v[2]));
         drain();
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      inv_gain = cordic_inv_gain();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_headings();
      test_span_extremes();
      test_clamps();
      test_random_sweep();
      repeat (3 * PIPE_LATENCY) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

   initial begin
      #10ms;
      $display("tb failed");
      $finish;
   end

endmodule

>>> filelist.f
sv/cai_pkg.sv
sv/cai_front.sv
sv/cai_cordic_stage.sv
sv/cai_back.sv
sv/cylindrical_arm_inverse_kinematics.sv
tb/sv/tb.sv
